### design/epsm_pkg.sv
// Shared types, register codes and constants of the encoder pulse speed meter.
`default_nettype none
package epsm_pkg;

  localparam int COUNTER_BITS_DEF  = 16;
  localparam int SAMPLES_PER_GROUP = 4;
  localparam int SPG_SHIFT         = $clog2(SAMPLES_PER_GROUP);
  localparam int NUM_BITS          = 20;
  localparam int THR_BITS          = 16;
  localparam int OVF_BITS          = 16;
  localparam int SPEED_BITS        = 21;
  localparam int AVG_BITS          = 22;
  localparam int SUM_BITS          = 24;
  localparam int CFG_IDX_BITS      = 8;
  localparam int CFG_DATA_BITS     = 20;
  localparam int STEP_BITS         = $clog2(NUM_BITS);

  localparam logic [NUM_BITS-1:0] NUMERATOR_RESET = 20'd50000;
  localparam logic [THR_BITS-1:0] THRESHOLD_RESET = 16'd5;
  localparam logic [OVF_BITS-1:0] OVF_LIMIT_RESET = 16'hFFFF;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_NUMERATOR = 8'd0,
    REG_THRESHOLD = 8'd1,
    REG_INVERT    = 8'd2,
    REG_OVF_LIMIT = 8'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    OP_CAPTURE = 2'd0,
    OP_TICK    = 2'd1,
    OP_READ    = 2'd2
  } opcode_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] capture_value;
    logic        direction_level;
  } in_word_t;

  typedef struct packed {
    logic signed [SPEED_BITS-1:0] speed_value;
    logic                         speed_updated;
  } out_word_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_AVG,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic accept;
    logic div_step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic fall_edge;
    logic div_last;
  } status_t;

endpackage
`default_nettype wire

### design/epsm_ctrl.sv
// Controller state machine sequencing acceptance, division, averaging and output.
`default_nettype none
module epsm_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  input  wire epsm_pkg::status_t status,
  output epsm_pkg::cmd_t         cmd
);
  import epsm_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = status.fall_edge ? ST_DIV : ST_OUT;
        end
      end
      ST_DIV: begin
        if (status.div_last) begin
          state_nxt = ST_AVG;
        end
      end
      ST_AVG: state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready     = 1'b0;
    out_valid    = 1'b0;
    cmd          = '0;
    case (state_r)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      ST_DIV:  cmd.div_step = 1'b1;
      ST_AVG:  cmd.finish   = 1'b1;
      ST_OUT:  out_valid    = 1'b1;
      default: in_ready     = 1'b0;
    endcase
  end

endmodule
`default_nettype wire

### design/epsm_dp.sv
// Datapath with configuration, capture state, serial divider and group averaging.
`default_nettype none
module epsm_dp #(
  parameter int COUNTER_BITS = epsm_pkg::COUNTER_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_valid,
  input  wire logic [epsm_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  wire logic [epsm_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  wire epsm_pkg::in_word_t                  in_data,
  input  wire epsm_pkg::cmd_t                      cmd,
  output epsm_pkg::status_t                        status,
  output epsm_pkg::out_word_t                      out_data
);
  import epsm_pkg::*;

  localparam int CAP_BITS = (COUNTER_BITS < 16) ? COUNTER_BITS : 16;
  localparam int DIV_BITS = OVF_BITS + COUNTER_BITS + 1;
  localparam int WID_BITS = DIV_BITS + 1;

  logic [NUM_BITS-1:0]  numerator_r;
  logic [THR_BITS-1:0]  threshold_r;
  logic                 invert_r;
  logic [OVF_BITS-1:0]  ovf_limit_r;

  logic                        waiting_fall_r, waiting_fall_nxt;
  logic [CAP_BITS-1:0]         start_r, start_nxt;
  logic [OVF_BITS-1:0]         ovf_count_r, ovf_count_nxt;
  logic                        dir_neg_r, dir_neg_nxt;
  logic signed [SUM_BITS-1:0]  sum_r, sum_nxt;
  logic [SPG_SHIFT-1:0]        index_r, index_nxt;
  logic signed [AVG_BITS-1:0]  avg_r, avg_nxt;
  logic                        first_done_r, first_done_nxt;
  logic signed [AVG_BITS-1:0]  pub_r, pub_nxt;

  logic [DIV_BITS-1:0]  divisor_r, divisor_nxt;
  logic                 width_pos_r, width_pos_nxt;
  logic [NUM_BITS-1:0]  rem_r, rem_nxt;
  logic [NUM_BITS-1:0]  quo_r, quo_nxt;
  logic [STEP_BITS-1:0] step_r, step_nxt;
  out_word_t            out_r, out_nxt;

  logic [CAP_BITS-1:0]        cap;
  logic signed [WID_BITS-1:0] width;
  logic [NUM_BITS:0]          rem_shift;
  logic                       rem_ge;
  logic signed [SPEED_BITS-1:0] sample;
  logic signed [SUM_BITS-1:0] sample_ext;
  logic signed [SUM_BITS-1:0] avg_ext;
  logic signed [SUM_BITS-1:0] total;
  logic signed [SUM_BITS-1:0] total_bias;
  logic signed [SUM_BITS-1:0] total_div;
  logic signed [AVG_BITS-1:0] new_avg;
  logic signed [AVG_BITS:0]   mag;
  logic [AVG_BITS:0]          mag_abs;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      numerator_r <= NUMERATOR_RESET;
      threshold_r <= THRESHOLD_RESET;
      invert_r    <= 1'b0;
      ovf_limit_r <= OVF_LIMIT_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_NUMERATOR: numerator_r <= cfg_data[NUM_BITS-1:0];
        REG_THRESHOLD: threshold_r <= cfg_data[THR_BITS-1:0];
        REG_INVERT:    invert_r    <= cfg_data[0];
        REG_OVF_LIMIT: ovf_limit_r <= cfg_data[OVF_BITS-1:0];
        default:       invert_r    <= invert_r;
      endcase
    end
  end

  assign cap   = in_data.capture_value[CAP_BITS-1:0];
  assign width = $signed({2'b00, ovf_count_r, {COUNTER_BITS{1'b0}}})
               + $signed({{(WID_BITS-CAP_BITS){1'b0}}, cap})
               - $signed({{(WID_BITS-CAP_BITS){1'b0}}, start_r});

  assign rem_shift = {rem_r, quo_r[NUM_BITS-1]};
  assign rem_ge    = {{(DIV_BITS-NUM_BITS-1){1'b0}}, rem_shift} >= divisor_r;

  assign status.fall_edge = (in_data.opcode == OP_CAPTURE) && waiting_fall_r;
  assign status.div_last  = (step_r == STEP_BITS'(NUM_BITS - 1));

  always_comb begin
    sample     = width_pos_r ? $signed({1'b0, quo_r}) : '0;
    if (dir_neg_r) begin
      sample = -sample;
    end
    sample_ext = SUM_BITS'(sample);
    avg_ext    = SUM_BITS'(avg_r);
    total      = sum_r + (first_done_r ? avg_ext : sample_ext);
    total_bias = total + (total[SUM_BITS-1] ? SUM_BITS'(SAMPLES_PER_GROUP - 1) : '0);
    total_div  = total_bias >>> SPG_SHIFT;
    new_avg    = total_div[AVG_BITS-1:0];
    mag        = (AVG_BITS+1)'(new_avg) + (AVG_BITS+1)'(avg_r);
    mag_abs    = mag[AVG_BITS] ? $unsigned(-mag) : $unsigned(mag);
  end

  always_comb begin
    waiting_fall_nxt = waiting_fall_r;
    start_nxt        = start_r;
    ovf_count_nxt    = ovf_count_r;
    dir_neg_nxt      = dir_neg_r;
    sum_nxt          = sum_r;
    index_nxt        = index_r;
    avg_nxt          = avg_r;
    first_done_nxt   = first_done_r;
    pub_nxt          = pub_r;
    divisor_nxt      = divisor_r;
    width_pos_nxt    = width_pos_r;
    rem_nxt          = rem_r;
    quo_nxt          = quo_r;
    step_nxt         = step_r;
    out_nxt          = out_r;

    if (cmd.accept) begin
      out_nxt.speed_value   = pub_r[SPEED_BITS-1:0];
      out_nxt.speed_updated = 1'b0;
      case (in_data.opcode)
        OP_CAPTURE: begin
          if (!waiting_fall_r) begin
            ovf_count_nxt    = '0;
            start_nxt        = cap;
            dir_neg_nxt      = in_data.direction_level ^ invert_r;
            waiting_fall_nxt = 1'b1;
          end else begin
            waiting_fall_nxt = 1'b0;
            width_pos_nxt    = !width[WID_BITS-1] && (width != '0);
            divisor_nxt      = width[DIV_BITS-1:0];
            rem_nxt          = '0;
            quo_nxt          = numerator_r;
            step_nxt         = '0;
          end
        end
        OP_TICK: begin
          if (ovf_count_r < ovf_limit_r) begin
            ovf_count_nxt = ovf_count_r + 1'b1;
          end else begin
            ovf_count_nxt         = '0;
            pub_nxt               = '0;
            out_nxt.speed_value   = '0;
            out_nxt.speed_updated = (pub_r != '0);
          end
        end
        OP_READ: begin
          pub_nxt               = '0;
          out_nxt.speed_updated = (pub_r != '0);
        end
        default: pub_nxt = pub_r;
      endcase
    end

    if (cmd.div_step) begin
      rem_nxt  = rem_ge ? NUM_BITS'(rem_shift - divisor_r[NUM_BITS:0]) : rem_shift[NUM_BITS-1:0];
      quo_nxt  = {quo_r[NUM_BITS-2:0], rem_ge};
      step_nxt = step_r + 1'b1;
    end

    if (cmd.finish) begin
      if (index_r != SPG_SHIFT'(SAMPLES_PER_GROUP - 1)) begin
        sum_nxt   = sum_r + sample_ext;
        index_nxt = index_r + 1'b1;
      end else begin
        first_done_nxt = 1'b1;
        avg_nxt        = new_avg;
        if (mag_abs >= (AVG_BITS+1)'(threshold_r)) begin
          pub_nxt = new_avg;
        end
        sum_nxt   = '0;
        index_nxt = '0;
      end
      out_nxt.speed_value   = pub_nxt[SPEED_BITS-1:0];
      out_nxt.speed_updated = (pub_nxt != pub_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      waiting_fall_r <= 1'b0;
      start_r        <= '0;
      ovf_count_r    <= '0;
      dir_neg_r      <= 1'b0;
      sum_r          <= '0;
      index_r        <= '0;
      avg_r          <= '0;
      first_done_r   <= 1'b0;
      pub_r          <= '0;
      step_r         <= '0;
    end else begin
      waiting_fall_r <= waiting_fall_nxt;
      start_r        <= start_nxt;
      ovf_count_r    <= ovf_count_nxt;
      dir_neg_r      <= dir_neg_nxt;
      sum_r          <= sum_nxt;
      index_r        <= index_nxt;
      avg_r          <= avg_nxt;
      first_done_r   <= first_done_nxt;
      pub_r          <= pub_nxt;
      step_r         <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    divisor_r   <= divisor_nxt;
    width_pos_r <= width_pos_nxt;
    rem_r       <= rem_nxt;
    quo_r       <= quo_nxt;
    out_r       <= out_nxt;
  end

  assign out_data = out_r;

endmodule
`default_nettype wire

### design/encoder_pulse_speed_meter_top.sv
// Order: a rising edge, tick, read or unused code gives its word in the cycle after acceptance.
// A falling edge first runs 20 restoring divider steps, then the averaging state, then loads
// the output register. One word is in flight at a time, so the block takes no new word until
// the output of the last one has been accepted. Reset is synchronous and active low; it loads
// the register defaults and clears all state but the divider and output registers.
`default_nettype none
module encoder_pulse_speed_meter_top #(
  parameter int COUNTER_BITS = epsm_pkg::COUNTER_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire epsm_pkg::in_word_t                  in_data,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output epsm_pkg::out_word_t                      out_data,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [epsm_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  wire logic [epsm_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  import epsm_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  epsm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  epsm_dp #(
    .COUNTER_BITS (COUNTER_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire
